// ----- design/block_power_threshold_monitor_macros.svh -----
// Assertion macros shared by the block power threshold monitor
`ifndef BLOCK_POWER_THRESHOLD_MONITOR_MACROS_SVH
`define BLOCK_POWER_THRESHOLD_MONITOR_MACROS_SVH

// Same-cycle implication, inactive while reset is asserted
`define BPTM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bptm assertion failed");

// Next-cycle implication, also checked across reset
`define BPTM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("bptm assertion failed");

`endif

// ----- design/bptm_pkg.sv -----
// Shared types and constants of the block power threshold monitor
`timescale 1ns / 1ps
package bptm_pkg;

  localparam int SAMPLE_W      = 10;
  localparam int SQ_W          = 19;   // square of a 10-bit magnitude, at most 2^18
  localparam int POWER_W       = 19;
  localparam int BLOCK_SAMPLES = 128;
  localparam int BLOCK_SHIFT   = 7;    // log2 of BLOCK_SAMPLES
  localparam int POS_W         = 7;
  localparam int SQ_SUM_W      = SQ_W + BLOCK_SHIFT;
  localparam int THRESH_W      = 32;
  localparam int RAISE_W       = 4;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [RAISE_W-1:0] RAISE_RESET = 4'd10;

  // request types on the input channel
  localparam logic REQ_SAMPLE    = 1'b0;
  localparam logic REQ_BURST_END = 1'b1;

  // result kinds
  localparam logic KIND_BLOCK = 1'b0;
  localparam logic KIND_BURST = 1'b1;

  // register index decoded from the word address
  localparam logic REG_THRESHOLD   = 1'b0;
  localparam logic REG_RAISE_AFTER = 1'b1;

  typedef struct packed {
    logic [THRESH_W-1:0] power_threshold;
    logic [RAISE_W-1:0]  raise_after;
  } cfg_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic               result_kind;
    logic [POWER_W-1:0] power;
    logic               over_threshold;
    logic               raise_request;
  } result_t;

endpackage

// ----- design/bptm_fifo.sv -----
// Small register queue between the front and back parts
`timescale 1ns / 1ps
module bptm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [WIDTH-1:0]     push_data,
  input  logic                 pop,
  output logic [WIDTH-1:0]     pop_data,
  output bptm_pkg::fifo_stat_t stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_data   = mem[rd_ptr_r];

  // pointer wrap and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/bptm_front.sv -----
// Front part: takes samples, squares and accumulates, builds queue entries
`timescale 1ns / 1ps
module bptm_front #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bptm_pkg::cfg_t                        cfg,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_req_type,
  input  logic signed [bptm_pkg::SAMPLE_W-1:0]  in_sample,
  input  bptm_pkg::fifo_stat_t                  q_stat,
  output logic                                  push,
  output logic [2+bptm_pkg::POWER_W+$clog2(MAX_BLOCKS)+$clog2(MAX_BLOCKS+1)-1:0] push_data
);

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int SUM_W = bptm_pkg::POWER_W + $clog2(MAX_BLOCKS);

  logic                                adv;
  logic [bptm_pkg::SAMPLE_W-1:0]       raw;
  logic [bptm_pkg::SAMPLE_W-1:0]       mag;
  logic [bptm_pkg::SQ_W-1:0]           sq;

  logic                                p_valid_r;
  logic                                p_kind_r;
  logic [bptm_pkg::SQ_W-1:0]           p_sq_r;

  logic [bptm_pkg::POS_W-1:0]          pos_r, pos_nxt;
  logic [bptm_pkg::SQ_SUM_W-1:0]       ssum_r, ssum_nxt;
  logic [SUM_W-1:0]                    bsum_r, bsum_nxt;
  logic [CNT_W-1:0]                    bcnt_r, bcnt_nxt;
  logic [bptm_pkg::RAISE_W-1:0]        quiet_r, quiet_nxt;
  logic                                hit_r, hit_nxt;

  logic [bptm_pkg::SQ_SUM_W-1:0]       sum_full;
  logic [bptm_pkg::POWER_W-1:0]        blk_power;
  logic                                over;
  logic [bptm_pkg::RAISE_W:0]          quiet_inc;
  logic                                raise;

  // magnitude and square of the incoming sample
  assign raw = $unsigned(in_sample);
  assign mag = raw[bptm_pkg::SAMPLE_W-1] ? (bptm_pkg::SAMPLE_W'(0) - raw) : raw;
  assign sq  = bptm_pkg::SQ_W'(mag) * bptm_pkg::SQ_W'(mag);

  // the stage moves unless it holds an item and the queue is full
  assign adv      = !p_valid_r || !q_stat.full;
  assign in_stall = !adv;

  // block and burst bookkeeping
  always_comb begin
    pos_nxt   = pos_r;
    ssum_nxt  = ssum_r;
    bsum_nxt  = bsum_r;
    bcnt_nxt  = bcnt_r;
    quiet_nxt = quiet_r;
    hit_nxt   = hit_r;
    push      = 1'b0;
    push_data = '0;

    sum_full  = ssum_r + bptm_pkg::SQ_SUM_W'(p_sq_r);
    blk_power = bptm_pkg::POWER_W'(sum_full >> bptm_pkg::BLOCK_SHIFT);
    over      = bptm_pkg::THRESH_W'(blk_power) >= cfg.power_threshold;
    quiet_inc = {1'b0, quiet_r} + 1'b1;
    raise     = quiet_inc > {1'b0, cfg.raise_after};

    if (p_valid_r && adv) begin
      if (p_kind_r == bptm_pkg::REQ_SAMPLE) begin
        if (pos_r == bptm_pkg::POS_W'(bptm_pkg::BLOCK_SAMPLES - 1)) begin
          // block complete
          push      = 1'b1;
          push_data = {bptm_pkg::KIND_BLOCK, over, SUM_W'(blk_power), CNT_W'(0)};
          pos_nxt   = '0;
          ssum_nxt  = '0;
          if (over) begin
            hit_nxt = 1'b1;
          end
          if (bcnt_r < CNT_W'(MAX_BLOCKS)) begin
            bsum_nxt = bsum_r + SUM_W'(blk_power);
            bcnt_nxt = bcnt_r + 1'b1;
          end
        end else begin
          pos_nxt  = pos_r + 1'b1;
          ssum_nxt = sum_full;
        end
      end else begin
        // burst end: hand sum and count to the back part for averaging
        push      = 1'b1;
        push_data = {bptm_pkg::KIND_BURST, raise && !hit_r, bsum_r, bcnt_r};
        bsum_nxt  = '0;
        bcnt_nxt  = '0;
        hit_nxt   = 1'b0;
        if (hit_r || raise) begin
          quiet_nxt = '0;
        end else begin
          quiet_nxt = quiet_inc[bptm_pkg::RAISE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      pos_r     <= '0;
      ssum_r    <= '0;
      bsum_r    <= '0;
      bcnt_r    <= '0;
      quiet_r   <= '0;
      hit_r     <= 1'b0;
    end else begin
      if (adv) begin
        p_valid_r <= in_valid;
      end
      pos_r   <= pos_nxt;
      ssum_r  <= ssum_nxt;
      bsum_r  <= bsum_nxt;
      bcnt_r  <= bcnt_nxt;
      quiet_r <= quiet_nxt;
      hit_r   <= hit_nxt;
    end
  end

  // accepted request payload
  always_ff @(posedge clk) begin
    if (in_valid && adv) begin
      p_kind_r <= in_req_type;
      p_sq_r   <= sq;
    end
  end

endmodule

// ----- design/bptm_back.sv -----
// Back part: drains the queue, divides burst sums, drives the result register
`timescale 1ns / 1ps
module bptm_back #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  bptm_pkg::fifo_stat_t  q_stat,
  input  logic [2+bptm_pkg::POWER_W+$clog2(MAX_BLOCKS)+$clog2(MAX_BLOCKS+1)-1:0] q_data,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output bptm_pkg::result_t     res
);

  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int SUM_W   = bptm_pkg::POWER_W + $clog2(MAX_BLOCKS);
  localparam int ENTRY_W = 2 + SUM_W + CNT_W;
  localparam int STEP_W  = $clog2(SUM_W);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_DIV  = 3'b010,
    B_DONE = 3'b100
  } back_state_t;

  back_state_t         state_r, state_nxt;
  logic [SUM_W-1:0]    quo_r, quo_nxt;
  logic [CNT_W-1:0]    rem_r, rem_nxt;
  logic [CNT_W-1:0]    div_r, div_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                flag_r, flag_nxt;
  logic                out_valid_r, out_valid_nxt;
  bptm_pkg::result_t   res_r, res_nxt;

  logic                e_kind;
  logic                e_flag;
  logic [SUM_W-1:0]    e_val;
  logic [CNT_W-1:0]    e_cnt;
  logic                out_free;
  logic                load;
  logic [CNT_W:0]      shifted;
  logic [CNT_W:0]      diff;
  logic                ge;

  assign e_kind = q_data[ENTRY_W-1];
  assign e_flag = q_data[ENTRY_W-2];
  assign e_val  = q_data[CNT_W +: SUM_W];
  assign e_cnt  = q_data[CNT_W-1:0];

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign res       = res_r;

  // one restoring division step per cycle
  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign diff    = shifted - {1'b0, div_r};
  assign ge      = shifted >= {1'b0, div_r};

  always_comb begin
    state_nxt = state_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    div_nxt   = div_r;
    step_nxt  = step_r;
    flag_nxt  = flag_r;
    res_nxt   = res_r;
    pop       = 1'b0;
    load      = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (!q_stat.empty && out_free) begin
          pop = 1'b1;
          if (e_kind == bptm_pkg::KIND_BLOCK) begin
            load    = 1'b1;
            res_nxt = '{result_kind: bptm_pkg::KIND_BLOCK,
                        power: e_val[bptm_pkg::POWER_W-1:0],
                        over_threshold: e_flag, raise_request: 1'b0};
          end else if (e_cnt == '0) begin
            // empty burst reports zero
            load    = 1'b1;
            res_nxt = '{result_kind: bptm_pkg::KIND_BURST, power: '0,
                        over_threshold: 1'b0, raise_request: e_flag};
          end else begin
            quo_nxt   = e_val;
            div_nxt   = e_cnt;
            rem_nxt   = '0;
            step_nxt  = '0;
            flag_nxt  = e_flag;
            state_nxt = B_DIV;
          end
        end
      end
      B_DIV: begin
        rem_nxt = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], ge};
        if (step_r == STEP_W'(SUM_W - 1)) begin
          state_nxt = B_DONE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      B_DONE: begin
        if (out_free) begin
          load      = 1'b1;
          res_nxt   = '{result_kind: bptm_pkg::KIND_BURST,
                        power: quo_r[bptm_pkg::POWER_W-1:0],
                        over_threshold: 1'b0, raise_request: flag_r};
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase

    // result register: filled on load, emptied when taken
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
    div_r  <= div_nxt;
    step_r <= step_nxt;
    flag_r <= flag_nxt;
    res_r  <= res_nxt;
  end

endmodule

// ----- design/block_power_threshold_monitor.sv -----
// Top level of the block power threshold monitor
// Usage:
//   Input channel (in_valid/in_stall): in_req_type 0 carries a signed 10-bit
//   sample, 1 marks a burst end. Every 128th sample yields a block result
//   (mean square, over-threshold flag); each burst end yields the average of
//   the first MAX_BLOCKS block powers of the burst and the raise flag.
//   Output channel (out_valid/out_stall) carries one result per request that
//   produces one, in request order.
//   Throughput: one request per cycle while in_stall is low. A block result
//   passes the input stage, the queue and the result register. A burst average
//   goes through a radix-2 divider in the back part, one quotient bit per
//   cycle: 19 + log2(MAX_BLOCKS) steps. A four-entry queue between the
//   front and the divider lets samples keep flowing while it runs; in_stall
//   rises only when that queue is full.
//   Receiver stall holds the result register; the queue then fills and
//   in_stall follows.
//   Reset (rst_n low, synchronous) empties the pipeline and the queue, clears
//   all accumulators, sets power_threshold to 0 and raise_after to 10.
//   Registers on the APB port: 0x0 power_threshold, 0x4 raise_after.
`timescale 1ns / 1ps
`include "block_power_threshold_monitor_macros.svh"
module block_power_threshold_monitor #(
  parameter int MAX_BLOCKS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [bptm_pkg::ADDR_W-1:0]          paddr,
  input  logic [bptm_pkg::DATA_W-1:0]          pwdata,
  output logic [bptm_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_req_type,
  input  logic signed [bptm_pkg::SAMPLE_W-1:0] in_sample,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_result_kind,
  output logic [bptm_pkg::POWER_W-1:0]         out_power,
  output logic                                 out_over_threshold,
  output logic                                 out_raise_request
);

  localparam int CNT_W   = $clog2(MAX_BLOCKS + 1);
  localparam int SUM_W   = bptm_pkg::POWER_W + $clog2(MAX_BLOCKS);
  localparam int ENTRY_W = 2 + SUM_W + CNT_W;

  logic [bptm_pkg::THRESH_W-1:0] thresh_r;
  logic [bptm_pkg::RAISE_W-1:0]  raise_after_r;
  logic                          cfg_wr;
  bptm_pkg::cfg_t                cfg;

  logic                          push;
  logic [ENTRY_W-1:0]            push_data;
  logic                          pop;
  logic [ENTRY_W-1:0]            pop_data;
  bptm_pkg::fifo_stat_t          q_stat;
  bptm_pkg::result_t             res;
  logic                          flags_ok;

  // register writes
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r      <= '0;
      raise_after_r <= bptm_pkg::RAISE_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        bptm_pkg::REG_THRESHOLD:   thresh_r      <= pwdata;
        bptm_pkg::REG_RAISE_AFTER: raise_after_r <= pwdata[bptm_pkg::RAISE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[2])
      bptm_pkg::REG_THRESHOLD:   prdata = thresh_r;
      bptm_pkg::REG_RAISE_AFTER: prdata = bptm_pkg::DATA_W'(raise_after_r);
      default:                   prdata = '0;
    endcase
  end

  assign cfg.power_threshold = thresh_r;
  assign cfg.raise_after     = raise_after_r;

  bptm_front #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .in_sample   (in_sample),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data)
  );

  bptm_fifo #(
    .WIDTH (ENTRY_W),
    .DEPTH (bptm_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (q_stat)
  );

  bptm_back #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_result_kind    = res.result_kind;
  assign out_power          = res.power;
  assign out_over_threshold = res.over_threshold;
  assign out_raise_request  = res.raise_request;

  // block results never carry a raise, burst results never an over flag
  assign flags_ok = (out_result_kind == bptm_pkg::KIND_BLOCK) ? !out_raise_request
                                                              : !out_over_threshold;

  // checks
  `BPTM_ASSERT_IMPL(a_stall_only_when_full, in_stall, q_stat.full)
  `BPTM_ASSERT_IMPL(a_flags_match_kind, out_valid, flags_ok)
  `BPTM_ASSERT_IMPL(a_block_power_range, out_valid && !out_result_kind, out_power <= 19'd262144)
  `BPTM_ASSERT_NEXT(a_reset_empties, !rst_n, !out_valid && !in_stall && q_stat.empty)

endmodule
